>>> sv/gtb_pkg.sv
// Shared types, constants and field arithmetic for the GF(2^m) table builder.
package gtb_pkg;

    // Largest supported field degree and the table geometry that follows from it.
    localparam int MAX_DEGREE  = 8;
    localparam int TABLE_DEPTH = 1 << MAX_DEGREE;
    localparam int ELEM_W      = 8;
    localparam int POLY_W      = 9;
    localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;

    // Function codes of an input word.
    localparam logic FUNC_TRY  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_GEN   = 3'd1,
        STAT_BAD_CAND  = 3'd2,
        STAT_BAD_POLY  = 3'd3,
        STAT_NOT_READY = 3'd4,
        STAT_RANGE     = 3'd5
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POWER,
        S_FAIL,
        S_INV,
        S_FINISH,
        S_RD_DATA
    } state_t;

    // Input word.
    typedef struct packed {
        logic              func;
        logic [ELEM_W-1:0] operand;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [2:0]        status;
        logic [ELEM_W-1:0] order;
        logic [ELEM_W-1:0] generator_out;
        logic [ELEM_W-1:0] exp_value;
        logic [ELEM_W-1:0] log_value;
        logic [ELEM_W-1:0] inv_value;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    pw_init;
        logic    pw_step;
        logic    commit_ok;
        logic    commit_fail;
        logic    inv_start;
        logic    rd_issue;
        logic    emit;
        status_t emit_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;
        logic poly_ok;
        logic cand_ok;
        logic ready;
        logic idx_ok;
        logic pw_hit_one;
        logic pw_last;
        logic inv_done;
    } sts_t;

    // Mask of the field elements: bit k is set when the degree exceeds k.
    function automatic logic [ELEM_W-1:0] deg_mask(input logic [POLY_W-1:0] poly);
        logic [ELEM_W-1:0] m;
        m = '0;
        for (int k = 0; k < ELEM_W; k++)
        begin
            m[k] = |(poly >> (k + 1));
        end
        return m;
    endfunction

    // Product of two field elements reduced modulo the field polynomial.
    function automatic logic [ELEM_W-1:0] gf_mul(input logic [ELEM_W-1:0] a,
                                                 input logic [ELEM_W-1:0] b,
                                                 input logic [POLY_W-1:0] poly,
                                                 input logic [ELEM_W-1:0] mask);
        logic [POLY_W-1:0] acc;
        logic [POLY_W-1:0] hi;
        logic [ELEM_W-1:0] r;
        acc = {1'b0, a};
        hi  = {1'b0, mask} + 9'd1;
        r   = '0;
        for (int k = 0; k < ELEM_W; k++)
        begin
            if (b[k])
            begin
                r = r ^ acc[ELEM_W-1:0];
            end
            acc = {acc[POLY_W-2:0], 1'b0};
            if ((acc & hi) != '0)
            begin
                acc = acc ^ poly;
            end
        end
        return r & mask;
    endfunction

endpackage

>>> sv/gtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/gtb_ctrl.sv
// Controller state machine that sequences decode, power walk, inverse sweep and reads.
module gtb_ctrl
    import gtb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.func == FUNC_TRY)
                begin
                    state_next = (sts.poly_ok && sts.cand_ok) ? S_POWER : S_IDLE;
                end
                else
                begin
                    state_next = (sts.ready && sts.idx_ok) ? S_RD_DATA : S_IDLE;
                end
            end
            S_POWER:
            begin
                if (sts.pw_hit_one && sts.pw_last)
                begin
                    state_next = S_INV;
                end
                else if (sts.pw_hit_one || sts.pw_last)
                begin
                    state_next = S_FAIL;
                end
            end
            S_FAIL:    state_next = S_IDLE;
            S_INV:
            begin
                if (sts.inv_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:  state_next = S_IDLE;
            S_RD_DATA: state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = STAT_OK;
        busy            = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DECODE:
            begin
                if (sts.func == FUNC_TRY)
                begin
                    if (!sts.poly_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_BAD_POLY;
                    end
                    else if (!sts.cand_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_BAD_CAND;
                    end
                    else
                    begin
                        cmd.pw_init = 1'b1;
                    end
                end
                else
                begin
                    if (!sts.ready)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_NOT_READY;
                    end
                    else if (!sts.idx_ok)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = STAT_RANGE;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                    end
                end
            end
            S_POWER:
            begin
                cmd.pw_step = 1'b1;
                if (sts.pw_hit_one && sts.pw_last)
                begin
                    cmd.commit_ok = 1'b1;
                    cmd.inv_start = 1'b1;
                end
                else if (sts.pw_hit_one || sts.pw_last)
                begin
                    cmd.commit_fail = 1'b1;
                end
            end
            S_FAIL:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_NOT_GEN;
            end
            S_INV:
            begin
                cmd.emit = 1'b0;
            end
            S_FINISH, S_RD_DATA:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_status = STAT_OK;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/gtb_datapath.sv
// Datapath: field registers, power walk, inverse sweep pipeline, table RAMs and result word.
module gtb_datapath
    import gtb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_word_t          item,
    input  logic              cfg_we,
    input  logic [POLY_W-1:0] cfg_data,
    output logic [POLY_W-1:0] field_poly,
    input  cmd_t              cmd,
    output sts_t              sts,
    output out_word_t         result,
    output logic              result_valid
);

    logic [POLY_W-1:0] poly_reg;
    logic              ready_reg;
    logic [ELEM_W-1:0] gen_reg;
    logic              func_reg;
    logic [ELEM_W-1:0] opnd_reg;
    logic [ELEM_W-1:0] y_reg;
    logic [ELEM_W-1:0] i_reg;
    logic [ELEM_W-1:0] order_reg;
    logic [ELEM_W-1:0] a_reg;
    logic              act_reg;
    logic              v1_reg;
    logic [ELEM_W-1:0] a1_reg;
    logic              v2_reg;
    logic [ELEM_W-1:0] a2_reg;
    out_word_t         res_reg;
    logic              done_reg;

    logic [ELEM_W-1:0] mask;
    logic [ELEM_W-1:0] y_next;
    logic              hit_one;
    logic              last;

    logic              exp_we;
    logic [ELEM_W-1:0] exp_waddr;
    logic [ELEM_W-1:0] exp_wdata;
    logic [ELEM_W-1:0] exp_raddr;
    logic [ELEM_W-1:0] exp_rdata;
    logic              log_we;
    logic [ELEM_W-1:0] log_waddr;
    logic [ELEM_W-1:0] log_wdata;
    logic [ELEM_W-1:0] log_raddr;
    logic [ELEM_W-1:0] log_rdata;
    logic              inv_we;
    logic [ELEM_W-1:0] inv_waddr;
    logic [ELEM_W-1:0] inv_wdata;
    logic [ELEM_W-1:0] inv_rdata;
    logic              read_ok;

    // Field geometry and one power step.
    assign mask    = deg_mask(poly_reg);
    assign y_next  = gf_mul(y_reg, opnd_reg, poly_reg, mask);
    assign hit_one = (y_next == ELEM_W'(1));
    assign last    = (i_reg == mask);

    // Status toward the controller.
    always_comb
    begin
        sts            = '0;
        sts.func       = func_reg;
        sts.poly_ok    = |poly_reg[POLY_W-1:1];
        sts.cand_ok    = (opnd_reg != '0) && (opnd_reg <= mask);
        sts.ready      = ready_reg;
        sts.idx_ok     = (opnd_reg <= mask);
        sts.pw_hit_one = hit_one;
        sts.pw_last    = last;
        sts.inv_done   = !act_reg && !v1_reg && !v2_reg;
    end

    // Table RAM ports: the power walk writes exp and log, the sweep writes inv.
    always_comb
    begin
        exp_we    = cmd.pw_init | cmd.pw_step;
        exp_waddr = cmd.pw_init ? '0 : i_reg;
        exp_wdata = cmd.pw_init ? ELEM_W'(1) : y_next;
        log_we    = cmd.pw_init | cmd.pw_step;
        log_waddr = cmd.pw_init ? '0 : y_next;
        log_wdata = cmd.pw_init ? '0 : i_reg;
        inv_we    = cmd.inv_start | v2_reg;
        inv_waddr = cmd.inv_start ? '0 : a2_reg;
        inv_wdata = cmd.inv_start ? '0 : exp_rdata;
        log_raddr = cmd.rd_issue ? opnd_reg : a_reg;
        exp_raddr = cmd.rd_issue ? opnd_reg : ((mask - log_rdata) & mask);
    end

    gtb_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (exp_raddr),
        .rdata (exp_rdata)
    );

    gtb_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_wdata),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    gtb_ram #(.WIDTH(ELEM_W), .DEPTH(TABLE_DEPTH)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .raddr (opnd_reg),
        .rdata (inv_rdata)
    );

    // Field polynomial, ready flag and stored generator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg  <= POLY_RESET;
            ready_reg <= 1'b0;
            gen_reg   <= '0;
        end
        else if (cfg_we)
        begin
            poly_reg  <= cfg_data;
            ready_reg <= 1'b0;
            gen_reg   <= '0;
        end
        else if (cmd.commit_ok)
        begin
            ready_reg <= 1'b1;
            gen_reg   <= opnd_reg;
        end
        else if (cmd.commit_fail)
        begin
            ready_reg <= 1'b0;
            gen_reg   <= '0;
        end
    end

    // Input word capture and the power walk.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= item.func;
            opnd_reg  <= item.operand;
            order_reg <= '0;
        end
        if (cmd.pw_init)
        begin
            y_reg <= ELEM_W'(1);
            i_reg <= ELEM_W'(1);
        end
        else if (cmd.pw_step)
        begin
            y_reg     <= y_next;
            order_reg <= hit_one ? i_reg : '0;
            if (!hit_one && !last)
            begin
                i_reg <= i_reg + ELEM_W'(1);
            end
        end
    end

    // Inverse sweep: log read, then exp read, then inv write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            v1_reg <= act_reg;
            v2_reg <= v1_reg;
            if (cmd.inv_start)
            begin
                act_reg <= 1'b1;
            end
            else if (act_reg && (a_reg == mask))
            begin
                act_reg <= 1'b0;
            end
        end
    end

    // Sweep addresses travel alongside the valid bits.
    always_ff @(posedge clk)
    begin
        a1_reg <= a_reg;
        a2_reg <= a1_reg;
        if (cmd.inv_start)
        begin
            a_reg <= ELEM_W'(1);
        end
        else if (act_reg)
        begin
            a_reg <= a_reg + ELEM_W'(1);
        end
    end

    // Result word register and strobe.
    assign read_ok = (func_reg == FUNC_READ) && (cmd.emit_status == STAT_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.status        <= cmd.emit_status;
            res_reg.order         <= order_reg;
            res_reg.generator_out <= ready_reg ? gen_reg : '0;
            res_reg.exp_value     <= read_ok ? exp_rdata : '0;
            res_reg.log_value     <= read_ok ? log_rdata : '0;
            res_reg.inv_value     <= read_ok ? inv_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    assign field_poly   = poly_reg;
    assign result       = res_reg;
    assign result_valid = done_reg;

endmodule

>>> sv/gf2m_table_builder.sv
// Top level of the GF(2^m) log, antilog and inverse table builder.
//
// The field polynomial sits in one register on the APB port (byte address 0,
// reset value 285); writing it marks the tables not ready. An input word is
// taken when start is high and busy is low; func selects a try of the operand
// as generator or a read of all three tables at the operand as index.
// Each input word gives one result word on result, marked by result_valid
// for exactly one cycle; the receiver cannot stall it.
// A read passes through decode, one registered RAM read and the result
// register; a rejected try or read skips the RAM read.
// A try walks the powers of the candidate one per cycle through a single
// field multiplier; if the candidate is a generator, the try then sweeps
// the inverse table one entry per cycle through a three-stage log-read,
// exp-read, inv-write pipeline.
// busy stays high until the result is on its way, so one word is in work at
// a time. After reset the tables are not ready and reads answer not ready
// until a try succeeds.
module gf2m_table_builder
    import gtb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  in_word_t    item,
    output out_word_t   result,
    output logic        result_valid
);

    cmd_t              cmd;
    sts_t              sts;
    logic              cfg_we;
    logic [POLY_W-1:0] field_poly;

    // Register access decode: only the polynomial register at word zero.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {23'd0, field_poly} : 32'd0;

    gtb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    gtb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (pwdata[POLY_W-1:0]),
        .field_poly   (field_poly),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

>>> bench/gf2m_checker.sv
// Result checker for the GF(2^m) table builder: tracks the tables and compares every result word.
module gf2m_checker
    import gtb_pkg::*;
#(
    parameter logic [2:0] POLY_ADDR = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  in_word_t    item,
    input  out_word_t   result,
    input  logic        result_valid,
    output int          errors,
    output int          pending,
    output int          tables_built
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the field tables, the generator and the polynomial register.
    logic [7:0] exp_tab [0:255];
    logic [7:0] log_tab [0:255];
    logic [7:0] inv_tab [0:255];
    logic       tables_ok;
    logic [7:0] gen_elem;
    logic [8:0] poly_reg;

    out_word_t  pending_answers [$];
    int         mismatches;
    int         builds_count;

    // Degree of a nonzero polynomial: position of its top set bit.
    function automatic int poly_degree(input int p);
        int d;
        d = 0;
        while (p > 1)
        begin
            p = p >> 1;
            d++;
        end
        return d;
    endfunction

    // Shift-and-add product in GF(2^m), reduced as soon as the top bit appears.
    function automatic int field_mul(input int a, input int b, input int p, input int m);
        int r;
        int hi;
        r  = 0;
        hi = 1 << m;
        while (b != 0)
        begin
            if ((b & 1) != 0)
            begin
                r = r ^ a;
            end
            b = b >> 1;
            a = a << 1;
            if ((a & hi) != 0)
            begin
                a = a ^ p;
            end
        end
        return r & (hi - 1);
    endfunction

    // Works out the answer to one input word and applies its effect on the tables.
    function automatic out_word_t field_answer(input in_word_t w);
        out_word_t r;
        int        p;
        int        m;
        int        size;
        int        y;
        int        i;
        int        a;
        int        e;
        logic      hit;
        r    = '0;
        p    = poly_reg;
        m    = (p >= 2) ? poly_degree(p) : 0;
        size = 1 << m;
        if (w.func == FUNC_TRY)
        begin
            if (p < 2)
            begin
                r.status = STAT_BAD_POLY;
            end
            else if (w.operand == 0 || w.operand >= size)
            begin
                r.status = STAT_BAD_CAND;
            end
            else
            begin
                // Walk the powers until one comes back to 1 or the field runs out.
                y          = 1;
                i          = 1;
                hit        = 1'b0;
                exp_tab[0] = 8'd1;
                log_tab[0] = 8'd0;
                while (i < size && !hit)
                begin
                    y = field_mul(y, w.operand, p, m);
                    exp_tab[i & 255] = y[7:0];
                    log_tab[y & 255] = i[7:0];
                    if (y == 1)
                    begin
                        hit = 1'b1;
                    end
                    else
                    begin
                        i++;
                    end
                end
                r.order = hit ? i[7:0] : 8'd0;
                if (hit && i == size - 1)
                begin
                    // Full order: keep the generator and fill the inverse table.
                    gen_elem   = w.operand;
                    tables_ok  = 1'b1;
                    inv_tab[0] = 8'd0;
                    for (a = 1; a < size; a++)
                    begin
                        e = (size - 1 - int'(log_tab[a])) & 255;
                        inv_tab[a] = exp_tab[e];
                    end
                    builds_count++;
                    r.status = STAT_OK;
                end
                else
                begin
                    tables_ok = 1'b0;
                    gen_elem  = 8'd0;
                    r.status  = STAT_NOT_GEN;
                end
            end
        end
        else
        begin
            if (!tables_ok)
            begin
                r.status = STAT_NOT_READY;
            end
            else if (w.operand >= size)
            begin
                r.status = STAT_RANGE;
            end
            else
            begin
                r.status    = STAT_OK;
                r.exp_value = exp_tab[w.operand];
                r.log_value = log_tab[w.operand];
                r.inv_value = inv_tab[w.operand];
            end
        end
        r.generator_out = tables_ok ? gen_elem : 8'd0;
        return r;
    endfunction

    // Counts one differing field and reports it while the report budget lasts.
    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, name, want, got);
            end
        end
    endfunction

    // Follow register writes, accepted input words and result words at each edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 256; k++)
            begin
                exp_tab[k] = 8'd0;
                log_tab[k] = 8'd0;
                inv_tab[k] = 8'd0;
            end
            tables_ok    = 1'b0;
            gen_elem     = 8'd0;
            poly_reg     = POLY_RESET;
            pending_answers.delete();
            mismatches   = 0;
            builds_count = 0;
            errors       <= 0;
            pending      <= 0;
            tables_built <= 0;
        end
        else
        begin
            // A polynomial write invalidates the tables; a read must return the register.
            if (psel && penable && pready && paddr == POLY_ADDR)
            begin
                if (pwrite)
                begin
                    poly_reg  = pwdata[8:0];
                    tables_ok = 1'b0;
                    gen_elem  = 8'd0;
                end
                else
                begin
                    compare_field("field_poly readback", int'({23'd0, poly_reg}), int'(prdata));
                end
            end

            // Result words are checked against the oldest outstanding answer.
            if (result_valid)
            begin
                if (pending_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result word at %0t: %h", $realtime, result);
                    end
                end
                else
                begin
                    want = pending_answers.pop_front();
                    compare_field("status", want.status, result.status);
                    compare_field("order", want.order, result.order);
                    compare_field("generator_out", want.generator_out, result.generator_out);
                    compare_field("exp_value", want.exp_value, result.exp_value);
                    compare_field("log_value", want.log_value, result.log_value);
                    compare_field("inv_value", want.inv_value, result.inv_value);
                end
            end

            if (start && !busy)
            begin
                pending_answers.push_back(field_answer(item));
            end

            errors       <= mismatches;
            pending      <= pending_answers.size();
            tables_built <= builds_count;
        end
    end

endmodule

>>> bench/tb.sv
// Stimulus and verdict for the GF(2^m) table builder testbench.
module tb
    import gtb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] POLY_ADDR   = 3'd0;
    localparam int         ITEM_TARGET = 1195;
    localparam int         CYCLE_LIMIT = 2500000;

    // Primitive polynomials: eight of degree 8 and a spread of lower degrees.
    localparam logic [8*9-1:0]  WIDE_POLYS   = {9'd285, 9'd299, 9'd301, 9'd333,
                                                9'd351, 9'd355, 9'd357, 9'd361};
    localparam logic [22*9-1:0] NARROW_POLYS = {9'd3, 9'd7, 9'd11, 9'd13, 9'd19, 9'd25,
                                                9'd37, 9'd41, 9'd47, 9'd55, 9'd59, 9'd61,
                                                9'd67, 9'd91, 9'd97, 9'd103, 9'd109, 9'd115,
                                                9'd131, 9'd137, 9'd143, 9'd145};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    in_word_t    item;
    out_word_t   result;
    logic        result_valid;

    int          errors;
    int          pending;
    int          tables_built;
    int          cycles;
    int          idle_pct;
    int          n_try;
    int          n_read;
    int          n_cfg;

    gf2m_table_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid)
    );

    gf2m_checker #(.POLY_ADDR(POLY_ADDR)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .errors       (errors),
        .pending      (pending),
        .tables_built (tables_built)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Number of field elements for a polynomial; 1 when the polynomial is unusable.
    function automatic int field_size(input logic [8:0] p);
        int d;
        d = 0;
        while (p > 1)
        begin
            p = p >> 1;
            d++;
        end
        return 1 << d;
    endfunction

    // Mostly primitive polynomials of low degree, a few of degree 8, some arbitrary ones.
    function automatic logic [8:0] pick_poly();
        int r;
        r = $urandom_range(99, 0);
        if (r < 12)
        begin
            return WIDE_POLYS[9*$urandom_range(7, 0) +: 9];
        end
        else if (r < 70)
        begin
            return NARROW_POLYS[9*$urandom_range(21, 0) +: 9];
        end
        else if (r < 93)
        begin
            return 9'($urandom_range(511, 0));
        end
        return 9'($urandom_range(1, 0));
    endfunction

    // Candidates are usually legal field elements, sometimes zero or too large.
    function automatic logic [7:0] pick_candidate(input logic [8:0] p);
        int size;
        size = field_size(p);
        if (p < 2 || size > 255)
        begin
            return ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        end
        if ($urandom_range(99, 0) < 85)
        begin
            return 8'($urandom_range(size - 1, 1));
        end
        return ($urandom_range(1, 0) == 0) ? 8'd0 : 8'($urandom_range(255, size));
    endfunction

    // Table indexes stay mostly inside the field.
    function automatic logic [7:0] pick_index(input logic [8:0] p);
        int size;
        size = field_size(p);
        if (p >= 2 && $urandom_range(99, 0) < 85)
        begin
            return 8'($urandom_range(size - 1, 0));
        end
        return 8'($urandom_range(255, 0));
    endfunction

    // Offer one input word and hold it until the block takes it, then maybe idle.
    task automatic send_word(input logic f, input logic [7:0] op);
        in_word_t w;
        w.func    = f;
        w.operand = op;
        item  <= w;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (f == FUNC_TRY)
        begin
            n_try++;
        end
        else
        begin
            n_read++;
        end
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
    endtask

    // Stop sending until every outstanding result word has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    // Write the field polynomial, junk in the unused upper bits, then read it back.
    task automatic program_poly(input logic [8:0] p);
        logic [31:0] wd;
        wd      = $urandom();
        wd[8:0] = p;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POLY_ADDR;
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        n_cfg++;
    endtask

    initial
    begin : stimulus
        logic [8:0] poly;
        int         phase;
        int         burst;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        start    <= 1'b0;
        item     <= '0;
        cycles   <= 0;
        idle_pct = 0;
        n_try    = 0;
        n_read   = 0;
        n_cfg    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset polynomial: read before any build, zero candidate, then a real build.
        send_word(FUNC_READ, 8'd0);
        send_word(FUNC_TRY, 8'd0);
        send_word(FUNC_TRY, 8'd2);
        send_word(FUNC_READ, 8'd0);
        send_word(FUNC_READ, 8'd255);
        send_word(FUNC_READ, 8'd1);
        send_word(FUNC_READ, 8'd2);
        // The element 1 has order 1, so the tables fall back to not ready.
        send_word(FUNC_TRY, 8'd1);
        send_word(FUNC_READ, 8'd5);
        drain();

        // GF(8): candidates outside the field, a good one, reads past the end.
        program_poly(9'd13);
        send_word(FUNC_TRY, 8'd8);
        send_word(FUNC_TRY, 8'd255);
        send_word(FUNC_TRY, 8'd3);
        send_word(FUNC_READ, 8'd7);
        send_word(FUNC_READ, 8'd8);
        send_word(FUNC_READ, 8'd255);
        drain();

        // Unusable polynomials.
        program_poly(9'd1);
        send_word(FUNC_TRY, 8'd5);
        send_word(FUNC_READ, 8'd0);
        drain();
        program_poly(9'd0);
        send_word(FUNC_TRY, 8'd1);
        drain();

        // Smallest field, two elements.
        program_poly(9'd2);
        send_word(FUNC_TRY, 8'd1);
        send_word(FUNC_READ, 8'd0);
        send_word(FUNC_READ, 8'd1);
        send_word(FUNC_READ, 8'd2);
        drain();

        // Reducible polynomial x^2: the powers of x collapse to zero.
        program_poly(9'd4);
        send_word(FUNC_TRY, 8'd2);
        send_word(FUNC_READ, 8'd0);
        drain();

        // All polynomial bits set.
        program_poly(9'd511);
        send_word(FUNC_TRY, 8'd255);
        drain();

        // Random phases: a try followed by a burst of reads, with some stray words.
        phase = 0;
        while (n_try + n_read < ITEM_TARGET)
        begin
            case (phase % 3)
                1:       idle_pct = 61;
                2:       idle_pct = 9;
                default: idle_pct = 0;
            endcase
            poly = pick_poly();
            program_poly(poly);
            for (int s = 0; s < 6; s++)
            begin
                send_word(FUNC_TRY, pick_candidate(poly));
                burst = $urandom_range(12, 3);
                repeat (burst)
                begin
                    if ($urandom_range(9, 0) == 0)
                    begin
                        send_word(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
                    end
                    else
                    begin
                        send_word(FUNC_READ, pick_index(poly));
                    end
                end
                if ($urandom_range(4, 0) == 0)
                begin
                    drain();
                end
            end
            drain();
            phase++;
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d tries and %0d reads under %0d polynomial settings.",
                 n_try, n_read, n_cfg);
        $display("Full tables were built %0d times; %0d field mismatches seen.",
                 tables_built, errors);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
